### design/signed_radix_to_ascii_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for signed_radix_to_ascii
// Short forms of the concurrent checks used in the converter module.
// ----------------------------------------------------------------------------
`ifndef SIGNED_RADIX_TO_ASCII_MACROS_SVH
`define SIGNED_RADIX_TO_ASCII_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg
// Types and constants shared by the radix text converter and its divider.
// ----------------------------------------------------------------------------
package sra_pkg;

	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = 16;
	localparam int RADIX_W    = 5;
	localparam int NDIG_MAX   = 32;
	localparam int ND_W       = 6;
	localparam int BUF_AW     = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// Restoring division: a number of quotient bits per clock.
	localparam int DIV_STEPS  = 8;
	localparam int DIV_CYCLES = VALUE_W / DIV_STEPS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_RADIX       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_DIGITS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_DIGITS_HIGH = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_SIGN,
		ST_DIGITS
	} sra_state_t;

	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] dividend;
		logic [RADIX_W-1:0] divisor;
	} sra_div_req_t;

	typedef struct packed {
		logic               done;
		logic [VALUE_W-1:0] quotient;
		logic [DIGIT_W-1:0] remainder;
	} sra_div_rsp_t;

endpackage

### design/sra_divider.sv
// ----------------------------------------------------------------------------
// sra_divider
// Multi-cycle restoring divider of a 32-bit magnitude by a radix of at most
// sixteen, retiring a fixed number of quotient bits each clock.
// ----------------------------------------------------------------------------
module sra_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sra_pkg::sra_div_req_t req,
	output sra_pkg::sra_div_rsp_t rsp
);
	import sra_pkg::*;

	logic [VALUE_W-1:0]   dq_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [RADIX_W-1:0]   divisor_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [VALUE_W-1:0] dq_nxt;
	logic [DIGIT_W-1:0] rem_nxt;

	// The shifted partial remainder never exceeds 31, so five bits suffice.
	always_comb begin
		logic [VALUE_W-1:0] dq;
		logic [RADIX_W-1:0] rm;
		logic [RADIX_W-1:0] trial;
		dq = dq_q;
		rm = {1'b0, rem_q};
		for (int k = 0; k < DIV_STEPS; k++) begin
			trial = {rm[DIGIT_W-1:0], dq[VALUE_W-1]};
			if (trial >= divisor_q) begin
				rm = trial - divisor_q;
				dq = {dq[VALUE_W-2:0], 1'b1};
			end else begin
				rm = trial;
				dq = {dq[VALUE_W-2:0], 1'b0};
			end
		end
		dq_nxt  = dq;
		rem_nxt = rm[DIGIT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q      <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			dq_q  <= dq_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dq_q;
	assign rsp.remainder = rem_q;

endmodule

### design/signed_radix_to_ascii.sv
// ----------------------------------------------------------------------------
// signed_radix_to_ascii
// Converts a signed 32-bit integer into its text form in a configured radix.
// ----------------------------------------------------------------------------
// Each value is emitted as a stream of byte beats: a '-' first when the value
// is negative, then the digits most significant first, the final beat with
// last set. Digits come from a single divider, one division per digit, and
// are buffered until the last digit is found. The input is taken only when
// the previous value has been fully handed to the output register. The radix
// and the digit table are set through the configuration port, which must be
// written only while idle; after reset the radix is zero and every value
// produces no beats. A digit set that is invalid (radix below two or above
// MAX_RADIX, a zero, '+' or '-' digit, or a repeated digit) also produces no
// beats for the value.
`include "signed_radix_to_ascii_macros.svh"

module signed_radix_to_ascii #(
	parameter int MAX_RADIX = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [sra_pkg::VALUE_W-1:0]   value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [sra_pkg::CHAR_W-1:0]           char_out,
	output logic                                 last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sra_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sra_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import sra_pkg::*;

	sra_state_t state_q, state_d;

	logic [RADIX_W-1:0]    radix_q;
	logic [CFG_DATA_W-1:0] digits_low_q;
	logic [CFG_DATA_W-1:0] digits_high_q;

	logic [VALUE_W-1:0] mag_q;
	logic               neg_q;
	logic [ND_W-1:0]    nd_q;
	logic [DIGIT_W-1:0] buf_q [NDIG_MAX];

	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic [2*CFG_DATA_W-1:0] digit_tbl;
	logic                    set_ok;
	logic                    out_free;
	logic                    div_more;
	logic [BUF_AW-1:0]       rd_idx;
	logic [DIGIT_W-1:0]      rd_digit;
	logic [VALUE_W-1:0]      mag_in;

	// Control outputs of the sequencer
	logic               accept;
	logic               buf_we;
	logic               nd_dec;
	logic               out_load;
	logic [CHAR_W-1:0]  out_char_d;
	logic               out_last_d;

	sra_div_req_t div_req;
	sra_div_rsp_t div_rsp;

	sra_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign digit_tbl = {digits_high_q, digits_low_q};
	assign out_free  = !out_valid_q || out_ready;
	assign div_more  = (div_rsp.quotient != '0) && (nd_q < ND_W'(NDIG_MAX - 1));
	assign rd_idx    = BUF_AW'(nd_q - 1'b1);
	assign rd_digit  = buf_q[rd_idx];
	assign mag_in    = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value))
	                                    : VALUE_W'(value);

	// Radix range and digit set check over the first radix entries of the table.
	always_comb begin
		logic [CHAR_W-1:0] c;
		set_ok = 1'b1;
		if (radix_q < RADIX_W'(2) || radix_q > RADIX_W'(MAX_RADIX) ||
		    radix_q > RADIX_W'(NUM_DIGITS)) begin
			set_ok = 1'b0;
		end
		for (int i = 0; i < NUM_DIGITS; i++) begin
			c = digit_tbl[i*CHAR_W +: CHAR_W];
			if (RADIX_W'(i) < radix_q) begin
				if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS) begin
					set_ok = 1'b0;
				end
				for (int j = i + 1; j < NUM_DIGITS; j++) begin
					if (RADIX_W'(j) < radix_q &&
					    digit_tbl[j*CHAR_W +: CHAR_W] == c) begin
						set_ok = 1'b0;
					end
				end
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = set_ok ? ST_DIVIDE : ST_IDLE;
			end
			ST_DIVIDE: begin
				if (div_rsp.done && !div_more) state_d = neg_q ? ST_SIGN : ST_DIGITS;
			end
			ST_SIGN: begin
				if (out_free) state_d = ST_DIGITS;
			end
			ST_DIGITS: begin
				if (out_free && nd_q == ND_W'(1)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready         = 1'b0;
		accept           = 1'b0;
		buf_we           = 1'b0;
		nd_dec           = 1'b0;
		out_load         = 1'b0;
		out_char_d       = CHAR_MINUS;
		out_last_d       = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = mag_q;
		div_req.divisor  = radix_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
			end
			ST_CHECK: begin
				div_req.start = set_ok;
			end
			ST_DIVIDE: begin
				if (div_rsp.done) begin
					buf_we           = 1'b1;
					div_req.start    = div_more;
					div_req.dividend = div_rsp.quotient;
				end
			end
			ST_SIGN: begin
				out_load = out_free;
			end
			ST_DIGITS: begin
				out_load   = out_free;
				nd_dec     = out_free;
				out_char_d = digit_tbl[{rd_digit, 3'b000} +: CHAR_W];
				out_last_d = (nd_q == ND_W'(1));
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= '0;
			digits_low_q  <= '0;
			digits_high_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IDX_RADIX:       radix_q       <= cfg_data[RADIX_W-1:0];
				CFG_IDX_DIGITS_LOW:  digits_low_q  <= cfg_data;
				CFG_IDX_DIGITS_HIGH: digits_high_q <= cfg_data;
				default:             radix_q       <= radix_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q <= '0;
		end else if (accept) begin
			nd_q <= '0;
		end else if (buf_we) begin
			nd_q <= nd_q + 1'b1;
		end else if (nd_dec) begin
			nd_q <= nd_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag_in;
			neg_q <= value[VALUE_W-1];
		end
		if (buf_we) begin
			buf_q[BUF_AW'(nd_q)] <= div_rsp.remainder;
		end
	end

	// Output register: the next beat is loaded as soon as the slot frees up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			char_q <= out_char_d;
			last_q <= out_last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign char_out  = char_q;
	assign last      = last_q;
	assign cfg_ready = 1'b1;

	`SRA_ASSERT_SAME(a_nd_range, 1'b1, nd_q <= ND_W'(NDIG_MAX), "digit count overflow")
	`SRA_ASSERT_NEXT(a_last_to_idle, out_load && out_last_d, state_q == ST_IDLE, "last beat not followed by idle")
	`SRA_ASSERT_SAME(a_done_in_divide, div_rsp.done, state_q == ST_DIVIDE, "divider result outside divide phase")
	`SRA_ASSERT_NEXT(a_accept_clears, in_valid && in_ready, state_q == ST_CHECK && nd_q == '0, "accepted value did not start a fresh conversion")

endmodule
